FILE: src/tgarle_pkg.sv
// Shared types and constants for the run-length TGA pixel decoder.
package tgarle_pkg;

  localparam int ADDR_W   = 26;
  localparam int DIM_W    = 13;
  localparam int COL_W    = 12;
  localparam int PIXCNT_W = 25;
  localparam int ROWB_W   = 15;
  localparam int PIX_W    = 32;
  localparam int OUT_W    = 64;

  // Input action codes.
  localparam logic [1:0] ACT_START = 2'd0;
  localparam logic [1:0] ACT_BYTE  = 2'd1;
  localparam logic [1:0] ACT_STEP  = 2'd2;

  // Pixel depth codes; any other code behaves as 32-bit color.
  localparam logic [1:0] DEPTH_ALPHA8 = 2'd0;
  localparam logic [1:0] DEPTH_RGB24  = 2'd1;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_DEPTH     = 2'd2;
  localparam logic [1:0] REG_BOTTOM_UP = 2'd3;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_EMIT  = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PIX_W-1:0] pixel;
    logic             last;
  } cmd_t;

  // Live configuration plus values registered from it.
  typedef struct packed {
    logic [1:0]        depth;
    logic              bottom_up;
    logic [DIM_W-1:0]  width_eff;
    logic [ROWB_W-1:0] row_bytes;
    logic [ADDR_W-1:0] start_addr;
    logic [ADDR_W-1:0] total;
  } cfg_t;

  function automatic logic [2:0] bytes_per_pixel(input logic [1:0] depth);
    logic [2:0] bpp;
    case (depth)
      DEPTH_ALPHA8: bpp = 3'd1;
      DEPTH_RGB24:  bpp = 3'd3;
      default:      bpp = 3'd4;
    endcase
    return bpp;
  endfunction

endpackage

FILE: src/tgarle_front.sv
// Front end: input register, packet decode, pixel gathering and frame counting.
module tgarle_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_action,
  input  logic [7:0]            in_byte,
  input  tgarle_pkg::cfg_t      cfg,
  output logic                  push,
  output tgarle_pkg::cmd_t      push_cmd,
  input  logic                  push_ready
);
  import tgarle_pkg::*;

  typedef enum logic [2:0] {
    PH_CONTROL = 3'b001,
    PH_GATHER  = 3'b010,
    PH_RUN     = 3'b100
  } phase_t;

  // Input stage.
  logic       hold_valid;
  logic [1:0] hold_action;
  logic [7:0] hold_byte;
  logic       advance;

  // Decode state.
  phase_t              phase, phase_next;
  logic                is_run, is_run_next;
  logic [6:0]          remaining, remaining_next;
  logic [1:0]          gather_idx, gather_idx_next;
  logic [PIX_W-1:0]    gathered, gathered_next;
  logic [PIXCNT_W-1:0] pixels, pixels_next;
  logic                frame_done, frame_done_next;

  logic [PIX_W-1:0]    merged;
  logic [PIXCNT_W-1:0] pixels_inc;
  logic                last_hit;
  logic [2:0]          bpp;

  assign advance  = hold_valid && push_ready;
  assign in_ready = !hold_valid || push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_action <= in_action;
      hold_byte   <= in_byte;
    end
  end

  assign bpp        = bytes_per_pixel(cfg.depth);
  assign pixels_inc = pixels + PIXCNT_W'(1);
  assign last_hit   = {1'b0, pixels_inc} >= cfg.total;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      merged[8*i +: 8] = (gather_idx == 2'(i)) ? hold_byte : gathered[8*i +: 8];
    end
  end

  always_comb begin
    phase_next      = phase;
    is_run_next     = is_run;
    remaining_next  = remaining;
    gather_idx_next = gather_idx;
    gathered_next   = gathered;
    pixels_next     = pixels;
    frame_done_next = frame_done;
    push            = 1'b0;
    push_cmd.kind   = CMD_EMIT;
    push_cmd.pixel  = gathered;
    push_cmd.last   = last_hit;

    if (!hold_valid) begin
      // Nothing is held, so nothing is decoded or pushed.
    end else if (hold_action == ACT_START) begin
      phase_next      = PH_CONTROL;
      is_run_next     = 1'b0;
      remaining_next  = '0;
      gather_idx_next = '0;
      gathered_next   = '0;
      pixels_next     = '0;
      frame_done_next = (cfg.total == '0);
      push            = 1'b1;
      push_cmd.kind   = CMD_START;
    end else if (!frame_done) begin
      if (hold_action == ACT_BYTE) begin
        case (phase)
          PH_CONTROL: begin
            is_run_next     = hold_byte[7];
            remaining_next  = hold_byte[6:0];
            gather_idx_next = '0;
            phase_next      = PH_GATHER;
          end
          PH_GATHER: begin
            gathered_next = merged;
            if ({1'b0, gather_idx} + 3'd1 < bpp) begin
              gather_idx_next = gather_idx + 2'd1;
            end else begin
              gather_idx_next = '0;
              if (is_run) begin
                phase_next = (remaining == '0) ? PH_CONTROL : PH_RUN;
              end else if (remaining == '0) begin
                phase_next = PH_CONTROL;
              end else begin
                remaining_next = remaining - 7'd1;
              end
              push            = 1'b1;
              push_cmd.pixel  = merged;
              pixels_next     = pixels_inc;
              frame_done_next = last_hit;
            end
          end
          default: begin
            // A stream byte while run pixels are pending is dropped.
          end
        endcase
      end else if (hold_action == ACT_STEP && phase == PH_RUN) begin
        remaining_next  = remaining - 7'd1;
        if (remaining_next == '0) begin
          phase_next = PH_CONTROL;
        end
        push            = 1'b1;
        pixels_next     = pixels_inc;
        frame_done_next = last_hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_CONTROL;
      is_run     <= 1'b0;
      remaining  <= '0;
      gather_idx <= '0;
      gathered   <= '0;
      pixels     <= '0;
      frame_done <= 1'b0;
    end else if (advance) begin
      phase      <= phase_next;
      is_run     <= is_run_next;
      remaining  <= remaining_next;
      gather_idx <= gather_idx_next;
      gathered   <= gathered_next;
      pixels     <= pixels_next;
      frame_done <= frame_done_next;
    end
  end

endmodule

FILE: src/tgarle_queue.sv
// Small command queue between the decode front end and the address back end.
module tgarle_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  tgarle_pkg::cmd_t push_cmd,
  output logic             push_ready,
  output logic             pop_valid,
  output tgarle_pkg::cmd_t pop_cmd,
  input  logic             pop
);
  import tgarle_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: src/tgarle_back.sv
// Back end: address walk over rows, byte reordering and the output register.
module tgarle_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  input  tgarle_pkg::cmd_t       cmd,
  output logic                   cmd_pop,
  input  tgarle_pkg::cfg_t       cfg,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [tgarle_pkg::OUT_W-1:0] out_data,
  output logic                   out_last
);
  import tgarle_pkg::*;

  logic [ADDR_W-1:0] addr, addr_next;
  logic [COL_W-1:0]  col, col_next;
  logic [DIM_W-1:0]  col_inc;
  logic              row_wrap;
  logic [2:0]        bpp;
  logic [7:0]        b0, b1, b2, b3;
  logic [7:0]        first_b, second_b, third_b, fourth_b;
  logic              slot_free;

  assign slot_free = !out_valid || out_ready;
  assign cmd_pop   = cmd_valid && (cmd.kind == CMD_START || slot_free);

  assign bpp      = bytes_per_pixel(cfg.depth);
  assign col_inc  = {1'b0, col} + DIM_W'(1);
  assign row_wrap = col_inc >= cfg.width_eff;

  // Bottom-up images step back two rows after finishing one.
  always_comb begin
    addr_next = addr + ADDR_W'(bpp);
    col_next  = col_inc[COL_W-1:0];
    if (row_wrap) begin
      col_next = '0;
      if (cfg.bottom_up) begin
        addr_next = addr_next - ADDR_W'({cfg.row_bytes, 1'b0});
      end
    end
  end

  assign {b3, b2, b1, b0} = cmd.pixel;

  always_comb begin
    if (cfg.depth == DEPTH_ALPHA8) begin
      first_b  = b0;
      second_b = '0;
      third_b  = '0;
      fourth_b = '0;
    end else begin
      first_b  = b2;
      second_b = b1;
      third_b  = b0;
      fourth_b = (cfg.depth == DEPTH_RGB24) ? 8'd0 : b3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      addr <= '0;
      col  <= '0;
    end else if (cmd_pop) begin
      if (cmd.kind == CMD_START) begin
        addr <= cfg.bottom_up ? cfg.start_addr : '0;
        col  <= '0;
      end else begin
        addr <= addr_next;
        col  <= col_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_pop && cmd.kind == CMD_EMIT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop && cmd.kind == CMD_EMIT) begin
      out_data <= {(OUT_W - ADDR_W - 32)'(0), fourth_b, third_b, second_b, first_b, addr};
      out_last <= cmd.last;
    end
  end

endmodule

FILE: src/tga_rle_pixel_decoder.sv
// Top level of the run-length TGA pixel decoder: configuration registers and wiring.
//
//  Channel  | Group  | Handshake              | Contents
//  ---------+--------+------------------------+-------------------------------------
//  input    | s_axis | tvalid / tready        | tdata: data_byte; tuser: action
//  output   | m_axis | tvalid / tready        | tdata: address and four pixel bytes;
//           |        |                        | tlast: last_pixel
//  config   | cfg    | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// One word is accepted per cycle unless the input stalls; the output word for a pixel
// passes from the input register through the command queue before the output register
// loads. Reset is synchronous and clears all control state. The input stalls only when
// the four-entry command queue is full, which happens when the output side is held off;
// configuration writes are always taken.
module tga_rle_pixel_decoder #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [25:0] byte_address, [33:26] first_byte, [41:34] second_byte,
  // [49:42] third_byte, [57:50] fourth_byte, [63:58] zero
  output logic [63:0] m_axis_tdata,
  output logic        m_axis_tlast,   // last_pixel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import tgarle_pkg::*;

  localparam logic [16:0] MaxW = 17'(MAX_WIDTH);
  localparam logic [16:0] MaxH = 17'(MAX_HEIGHT);

  logic [DIM_W-1:0]  image_width, image_height;
  logic [1:0]        pixel_depth;
  logic              bottom_up;

  logic [DIM_W-1:0]  width_eff, height_eff, height_m1;
  logic [ROWB_W-1:0] row_bytes_now;
  logic [ROWB_W-1:0] row_bytes;
  logic [ADDR_W-1:0] start_addr;
  logic [ADDR_W-1:0] total;
  cfg_t              cfg;

  logic              push, push_ready, pop, pop_valid;
  cmd_t              push_cmd, pop_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1);
      image_height <= DIM_W'(1);
      pixel_depth  <= 2'd2;
      bottom_up    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WIDTH:     image_width  <= cfg_data;
        REG_HEIGHT:    image_height <= cfg_data;
        REG_DEPTH:     pixel_depth  <= cfg_data[1:0];
        REG_BOTTOM_UP: bottom_up    <= cfg_data[0];
        default:       bottom_up    <= bottom_up;
      endcase
    end
  end

  assign width_eff  = ({4'd0, image_width} > MaxW) ? MaxW[DIM_W-1:0] : image_width;
  assign height_eff = ({4'd0, image_height} > MaxH) ? MaxH[DIM_W-1:0] : image_height;
  assign height_m1  = (height_eff == '0) ? '0 : height_eff - DIM_W'(1);

  always_comb begin
    case (pixel_depth)
      DEPTH_ALPHA8: row_bytes_now = ROWB_W'(width_eff);
      DEPTH_RGB24:  row_bytes_now = ROWB_W'(width_eff) + ROWB_W'({width_eff, 1'b0});
      default:      row_bytes_now = ROWB_W'({width_eff, 2'b00});
    endcase
  end

  // Derived frame geometry, registered from the configuration registers.
  always_ff @(posedge clk) begin
    row_bytes  <= row_bytes_now;
    start_addr <= ADDR_W'(height_m1) * ADDR_W'(row_bytes_now);
    total      <= ADDR_W'(width_eff) * ADDR_W'(height_eff);
  end

  assign cfg.depth      = pixel_depth;
  assign cfg.bottom_up  = bottom_up;
  assign cfg.width_eff  = width_eff;
  assign cfg.row_bytes  = row_bytes;
  assign cfg.start_addr = start_addr;
  assign cfg.total      = total;

  tgarle_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser),
    .in_byte    (s_axis_tdata),
    .cfg        (cfg),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  tgarle_queue #(
    .DEPTH (4)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  tgarle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (pop_valid),
    .cmd       (pop_cmd),
    .cmd_pop   (pop),
    .cfg       (cfg),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
